@@ hdl/bls_pkg.sv @@
// bls_pkg: shared constants and item codes of the line stepper
// no dependencies; imported by every other file of the block

package bls_pkg;

  // default coordinate width, signed
  localparam int COORD_BITS = 11;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // item function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

endpackage

@@ hdl/bls_stream_if.sv @@
// bls_stream_if: valid/ready channels carrying input items and pixel items
// depends on bls_pkg for the function code and default coordinate width

interface bls_in_if #(
  parameter int CoordBits = bls_pkg::COORD_BITS
);
  import bls_pkg::*;

  logic                        valid;
  logic                        ready;
  func_e                       func;
  logic signed [CoordBits-1:0] start_x;
  logic signed [CoordBits-1:0] start_y;
  logic signed [CoordBits-1:0] end_x;
  logic signed [CoordBits-1:0] end_y;

  modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_out_if #(
  parameter int CoordBits = bls_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] pixel_x;
  logic signed [CoordBits-1:0] pixel_y;
  logic                        last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

@@ hdl/bresenham_line_stepper.sv @@
// bresenham_line_stepper: integer line rasteriser for any slope, at most one pixel per item
// path: an item passes the front stage register, the queue and the back output register to out_o
// throughput: one item per cycle when out_o does not stall
// reset: asynchronous, active low; no line active, queue empty, no pending pixel
// depends on bls_pkg, bls_stream_if, bls_front, bls_queue and bls_back

module bresenham_line_stepper #(
  parameter int CoordBits  = bls_pkg::COORD_BITS,
  parameter int QueueDepth = bls_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bls_in_if.sink    in_i,
  bls_out_if.source out_o
);
  import bls_pkg::*;

  localparam int ErrW = CoordBits + 3;

  // command handed from the front to the back through the queue;
  // a start carries the ordered first endpoint, the minor delta, the major
  // delta as step count, the direction flags and the seeded decision value,
  // a step only its function code (the remaining fields are don't-care)
  typedef struct packed {
    func_e                       func;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic [CoordBits-1:0]        minor;
    logic [CoordBits-1:0]        steps;
    logic                        y_down;
    logic                        y_major;
    logic signed [ErrW-1:0]      err;
  } cmd_t;

  logic cf_valid, cf_ready;
  cmd_t cf_data;
  logic cb_valid, cb_ready;
  cmd_t cb_data;

  // front: swaps endpoints so x never falls, takes |dy|, picks the major
  // axis by comparing magnitudes and seeds the decision value
  bls_front #(
    .CoordBits (CoordBits),
    .cmd_t     (cmd_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cf_valid),
    .cmd_ready_i (cf_ready),
    .cmd_o       (cf_data)
  );

  // short fifo so a stall at the output does not immediately reach the input
  bls_queue #(
    .data_t (cmd_t),
    .Depth  (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cf_valid),
    .push_ready_o (cf_ready),
    .push_data_i  (cf_data),
    .pop_valid_o  (cb_valid),
    .pop_ready_i  (cb_ready),
    .pop_data_o   (cb_data)
  );

  // back: a start loads the line and emits its first pixel; each step
  // advances along the major axis, moving the minor axis when the decision
  // value is not negative; a step with no line active is dropped silently
  bls_back #(
    .CoordBits (CoordBits),
    .cmd_t     (cmd_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cb_valid),
    .cmd_ready_o (cb_ready),
    .cmd_i       (cb_data),
    .out_o       (out_o)
  );

endmodule

@@ hdl/bls_queue.sv @@
// bls_queue: small register fifo decoupling the front from the back
// depends on bls_pkg for the default depth

module bls_queue #(
  parameter type data_t = logic,
  parameter int  Depth  = bls_pkg::QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  data_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output data_t pop_data_o
);
  import bls_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  data_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  always_comb begin
    push_ready_o = (count_q != CntW'(Depth));
    pop_valid_o  = (count_q != '0);
    pop_data_o   = mem_q[rd_ptr_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    count_d      = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count missed a push");
`endif

endmodule

@@ hdl/bls_front.sv @@
// bls_front: accepts items, orders endpoints and classifies the line
// depends on bls_pkg and bls_in_if; feeds bls_queue with a command struct

module bls_front #(
  parameter int  CoordBits = bls_pkg::COORD_BITS,
  parameter type cmd_t     = logic
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bls_in_if.sink   in_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);
  import bls_pkg::*;

  localparam int ErrW = CoordBits + 3;

  // first stage: swapped endpoints and raw deltas
  logic                        st_valid_q;
  func_e                       st_func_q;
  logic signed [CoordBits-1:0] st_ax_q, st_ay_q;
  logic [CoordBits-1:0]        st_dx_q;
  logic signed [CoordBits:0]   st_dy_q;

  logic                        take;
  logic                        swap;
  logic signed [CoordBits-1:0] ax, ay, bx, by;
  logic [CoordBits:0]          dx_full;
  logic signed [CoordBits:0]   dy_full;
  logic [CoordBits:0]          dy_mag;
  logic [CoordBits-1:0]        abs_dy;
  logic                        y_major;
  logic [CoordBits-1:0]        major, minor;

  always_comb begin
    in_i.ready = !st_valid_q || cmd_ready_i;
    take       = in_i.valid && in_i.ready;
    swap       = (in_i.start_x > in_i.end_x);
    ax         = swap ? in_i.end_x   : in_i.start_x;
    ay         = swap ? in_i.end_y   : in_i.start_y;
    bx         = swap ? in_i.start_x : in_i.end_x;
    by         = swap ? in_i.start_y : in_i.end_y;
    dx_full    = {bx[CoordBits-1], bx} - {ax[CoordBits-1], ax};
    dy_full    = {by[CoordBits-1], by} - {ay[CoordBits-1], ay};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      st_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_func_q <= in_i.func;
      st_ax_q   <= ax;
      st_ay_q   <= ay;
      st_dx_q   <= dx_full[CoordBits-1:0];
      st_dy_q   <= dy_full;
    end
  end

  // second stage: magnitudes, major axis and starting decision value
  always_comb begin
    dy_mag        = st_dy_q[CoordBits] ? (~st_dy_q + (CoordBits+1)'(1)) : st_dy_q;
    abs_dy        = dy_mag[CoordBits-1:0];
    y_major       = abs_dy > st_dx_q;
    major         = y_major ? abs_dy  : st_dx_q;
    minor         = y_major ? st_dx_q : abs_dy;
    cmd_valid_o   = st_valid_q;
    cmd_o.func    = st_func_q;
    cmd_o.ax      = st_ax_q;
    cmd_o.ay      = st_ay_q;
    cmd_o.minor   = minor;
    cmd_o.steps   = major;
    cmd_o.y_down  = st_dy_q[CoordBits];
    cmd_o.y_major = y_major;
    cmd_o.err     = ErrW'({2'b00, minor, 1'b0}) - ErrW'({3'b000, major});
  end

endmodule

@@ hdl/bls_back.sv @@
// bls_back: walks the active line at most one pixel per command, holds the output register
// depends on bls_pkg and bls_out_if; pops commands from bls_queue

module bls_back #(
  parameter int  CoordBits = bls_pkg::COORD_BITS,
  parameter type cmd_t     = logic
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  bls_out_if.source out_o
);
  import bls_pkg::*;

  localparam int ErrW = CoordBits + 3;

  // line state
  logic                        active_q, active_d;
  logic                        y_down_q, y_down_d;
  logic                        y_major_q, y_major_d;
  logic [CoordBits-1:0]        steps_q, steps_d;
  logic signed [ErrW-1:0]      err_q, err_d;
  logic signed [ErrW-1:0]      inc_minor_q, inc_minor_d;
  logic signed [ErrW-1:0]      inc_diag_q, inc_diag_d;
  logic signed [CoordBits-1:0] x_q, x_d;
  logic signed [CoordBits-1:0] y_q, y_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic signed [CoordBits-1:0] px_q;
  logic signed [CoordBits-1:0] py_q;
  logic                        last_q, last_d;

  logic                        pop, is_start, emit, err_neg;
  logic signed [CoordBits-1:0] y_next;
  logic [ErrW-1:0]             two_minor;

  always_comb begin
    cmd_ready_o = !out_valid_q || out_o.ready;
    pop         = cmd_valid_i && cmd_ready_o;
    is_start    = (cmd_i.func == FUNC_START);
    emit        = pop && (is_start || active_q);
    err_neg     = err_q[ErrW-1];
    y_next      = y_down_q ? (y_q - CoordBits'(1)) : (y_q + CoordBits'(1));
    two_minor   = ErrW'({2'b00, cmd_i.minor, 1'b0});

    active_d    = active_q;
    y_down_d    = y_down_q;
    y_major_d   = y_major_q;
    steps_d     = steps_q;
    err_d       = err_q;
    inc_minor_d = inc_minor_q;
    inc_diag_d  = inc_diag_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;

    if (pop && is_start) begin
      x_d         = cmd_i.ax;
      y_d         = cmd_i.ay;
      err_d       = cmd_i.err;
      steps_d     = cmd_i.steps;
      y_down_d    = cmd_i.y_down;
      y_major_d   = cmd_i.y_major;
      inc_minor_d = two_minor;
      inc_diag_d  = two_minor - ErrW'({2'b00, cmd_i.steps, 1'b0});
      active_d    = (cmd_i.steps != '0);
      last_d      = (cmd_i.steps == '0);
    end else if (pop && active_q) begin
      err_d = err_q + (err_neg ? inc_minor_q : inc_diag_q);
      if (y_major_q) begin
        y_d = y_next;
        x_d = err_neg ? x_q : (x_q + CoordBits'(1));
      end else begin
        x_d = x_q + CoordBits'(1);
        y_d = err_neg ? y_q : y_next;
      end
      steps_d  = steps_q - CoordBits'(1);
      active_d = (steps_q != CoordBits'(1));
      last_d   = (steps_q == CoordBits'(1));
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      y_down_q    <= 1'b0;
      y_major_q   <= 1'b0;
      steps_q     <= '0;
      err_q       <= '0;
      inc_minor_q <= '0;
      inc_diag_q  <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      y_down_q    <= y_down_d;
      y_major_q   <= y_major_d;
      steps_q     <= steps_d;
      err_q       <= err_d;
      inc_minor_q <= inc_minor_d;
      inc_diag_q  <= inc_diag_d;
      x_q         <= x_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= x_d;
      py_q   <= y_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pixel_x = px_q;
  assign out_o.pixel_y = py_q;
  assign out_o.last    = last_q;

`ifndef SYNTHESIS
  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (steps_q != '0))
    else $error("line active with no pixels left");

  a_final_step_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !is_start && active_q && steps_q == CoordBits'(1)) |=> (!active_q && last_q))
    else $error("final pixel did not end the line");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(px_q) && $stable(py_q)))
    else $error("pending pixel overwritten");
`endif

endmodule
